// ===== rtl/rps_pkg.sv =====
// ----------------------------------------------------------------------------
// rps_pkg
// Shared types, operation codes and defaults of the priority scheduler.
// ----------------------------------------------------------------------------
package rps_pkg;

    // Default sizing
    localparam int NUM_PRIO_DEF   = 32;
    localparam int DELAY_BITS_DEF = 32;

    // Operation codes
    localparam logic [1:0] FUNC_CREATE = 2'd0;
    localparam logic [1:0] FUNC_START  = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;
    localparam logic [1:0] FUNC_DELAY  = 2'd3;

    // Status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_EXISTS  = 2'd1;
    localparam logic [1:0] STAT_STARTED = 2'd2;

    // Input transaction
    typedef struct packed {
        logic [1:0]  func;
        logic [4:0]  prio;
        logic [31:0] delay_ticks;
    } t_in_item;

    // Output transaction
    typedef struct packed {
        logic        switch_now;
        logic [4:0]  next_prio;
        logic        none_ready;
        logic [1:0]  status;
        logic [31:0] time_now;
    } t_out_item;

endpackage

// ===== rtl/rps_delay_mem.sv =====
// ----------------------------------------------------------------------------
// rps_delay_mem
// Delay counter store: one write port, one registered read port, with a
// valid bit per entry so that entries never written read as zero.
// ----------------------------------------------------------------------------
module rps_delay_mem import rps_pkg::*; #(
    parameter int DEPTH = NUM_PRIO_DEF,
    parameter int WIDTH = DELAY_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rd_q;
    logic             r_rd_vld;

    // Track written entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_valid[i_rd_addr];
            end
        end
    end

    // Storage array
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_q <= r_mem[i_rd_addr];
        end
    end

    // Unwritten entries read as zero
    assign o_rd_data = r_rd_vld ? r_rd_q : '0;

endmodule

// ===== rtl/rps_prio_enc.sv =====
// ----------------------------------------------------------------------------
// rps_prio_enc
// Lowest-set-bit finder: picks the highest-priority ready task.
// ----------------------------------------------------------------------------
module rps_prio_enc import rps_pkg::*; #(
    parameter int NUM_PRIO = NUM_PRIO_DEF
) (
    input  logic [NUM_PRIO-1:0]         i_mask,
    output logic                        o_any,
    output logic [$clog2(NUM_PRIO)-1:0] o_idx
);

    localparam int PW = $clog2(NUM_PRIO);

    // Scan from the top so the lowest set bit wins
    always_comb begin
        o_idx = '0;
        for (int i = NUM_PRIO - 1; i >= 0; i--) begin
            if (i_mask[i]) begin
                o_idx = PW'(i);
            end
        end
    end

    assign o_any = |i_mask;

endmodule

// ===== rtl/rtos_priority_scheduler_top.sv =====
// Sequence: an accepted item goes to ST_FIN, where the registered result is
//   issued once the output is free; a tick after start first passes ST_SCAN.
// Flow: a new item is accepted only in ST_IDLE, after the last result has
//   been issued; the walk of the delay memory in ST_SCAN holds off the input.
// Reset: synchronous, active low; clears masks, running task, started flag,
//   tick count and the delay memory valid bits at once, with no clearing pass.
// ----------------------------------------------------------------------------
// rtos_priority_scheduler_top
// Bitmap priority scheduler with per-task tick delays kept in a memory.
// ----------------------------------------------------------------------------
module rtos_priority_scheduler_top import rps_pkg::*; #(
    parameter int NUM_PRIO   = NUM_PRIO_DEF,
    parameter int DELAY_BITS = DELAY_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    localparam int PW = $clog2(NUM_PRIO);
    localparam int CW = $clog2(NUM_PRIO + 1);
    localparam logic [31:0] DelayMax = 32'((64'd1 << DELAY_BITS) - 64'd1);

    // State codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [NUM_PRIO-1:0] r_created, n_created;
    logic [NUM_PRIO-1:0] r_ready, n_ready;
    logic [PW-1:0]       r_running, n_running;
    logic                r_started, n_started;
    logic [31:0]         r_tick, n_tick;
    logic [1:0]          r_func, n_func;
    logic [1:0]          r_status, n_status;
    logic                r_resched, n_resched;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_pend, n_pend;
    logic [PW-1:0]       r_wb_idx, n_wb_idx;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    logic                  in_acc;
    logic                  out_free;
    logic                  enc_any;
    logic [PW-1:0]         enc_idx;
    logic [6:0]            enc_x;
    logic [6:0]            prio_x;
    logic [PW-1:0]         prio_idx;
    logic                  prio_oob;
    logic [31:0]           ticks_sat;
    logic                  wr_en;
    logic [PW-1:0]         wr_addr;
    logic [DELAY_BITS-1:0] wr_data;
    logic                  rd_en;
    logic [PW-1:0]         rd_addr;
    logic [DELAY_BITS-1:0] rd_data;
    logic                  sw;

    rps_prio_enc #(.NUM_PRIO(NUM_PRIO)) u_enc (
        .i_mask (r_ready),
        .o_any  (enc_any),
        .o_idx  (enc_idx)
    );

    rps_delay_mem #(.DEPTH(NUM_PRIO), .WIDTH(DELAY_BITS)) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Handshake
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Field decode
    assign prio_x    = {2'b00, i_in.prio};
    assign prio_idx  = prio_x[PW-1:0];
    assign prio_oob  = prio_x >= 7'(NUM_PRIO);
    assign ticks_sat = (i_in.delay_ticks > DelayMax) ? DelayMax : i_in.delay_ticks;
    assign enc_x     = 7'(enc_idx);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_created   = r_created;
        n_ready     = r_ready;
        n_running   = r_running;
        n_started   = r_started;
        n_tick      = r_tick;
        n_func      = r_func;
        n_status    = r_status;
        n_resched   = r_resched;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_wb_idx    = r_wb_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_addr     = r_wb_idx;
        wr_data     = rd_data - DELAY_BITS'(1);
        rd_en       = 1'b0;
        rd_addr     = r_idx[PW-1:0];
        sw          = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_func    = i_in.func;
                    n_status  = STAT_OK;
                    n_resched = 1'b0;
                    n_idx     = '0;
                    n_pend    = 1'b0;
                    n_state   = ST_FIN;
                    unique case (i_in.func)
                        FUNC_CREATE: begin
                            if (prio_oob || r_created[prio_idx]) begin
                                n_status = STAT_EXISTS;
                            end else begin
                                n_created[prio_idx] = 1'b1;
                                n_ready[prio_idx]   = 1'b1;
                            end
                        end
                        FUNC_START: begin
                            if (r_started) begin
                                n_status = STAT_STARTED;
                            end
                        end
                        FUNC_TICK: begin
                            n_tick = r_tick + 32'd1;
                            if (r_started) begin
                                n_resched = 1'b1;
                                n_state   = ST_SCAN;
                            end
                        end
                        FUNC_DELAY: begin
                            if (r_started && (i_in.delay_ticks != 32'd0)) begin
                                n_ready[r_running] = 1'b0;
                                wr_en     = 1'b1;
                                wr_addr   = r_running;
                                wr_data   = ticks_sat[DELAY_BITS-1:0];
                                n_resched = 1'b1;
                            end
                        end
                        default: begin
                            n_state = ST_FIN;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Issue the next read
                if (r_idx < CW'(NUM_PRIO)) begin
                    rd_en = 1'b1;
                    n_idx = r_idx + CW'(1);
                end
                n_pend   = r_idx < CW'(NUM_PRIO);
                n_wb_idx = rd_addr;
                // Decrement and write back the previous read
                if (r_pend && (rd_data != '0)) begin
                    wr_en = 1'b1;
                    if (rd_data == DELAY_BITS'(1)) begin
                        n_ready[r_wb_idx] = 1'b1;
                    end
                end
                if (r_idx == CW'(NUM_PRIO)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    if ((r_func == FUNC_START) && !r_started && enc_any) begin
                        sw        = 1'b1;
                        n_running = enc_idx;
                        n_started = 1'b1;
                    end else if (r_resched && enc_any && (enc_idx != r_running)) begin
                        sw        = 1'b1;
                        n_running = enc_idx;
                    end
                    n_out_valid      = 1'b1;
                    n_out.switch_now = sw;
                    n_out.next_prio  = enc_any ? enc_x[4:0] : 5'd0;
                    n_out.none_ready = !enc_any;
                    n_out.status     = r_status;
                    n_out.time_now   = r_tick;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_created   <= '0;
            r_ready     <= '0;
            r_running   <= '0;
            r_started   <= 1'b0;
            r_tick      <= '0;
            r_func      <= FUNC_CREATE;
            r_status    <= STAT_OK;
            r_resched   <= 1'b0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_created   <= n_created;
            r_ready     <= n_ready;
            r_running   <= n_running;
            r_started   <= n_started;
            r_tick      <= n_tick;
            r_func      <= n_func;
            r_status    <= n_status;
            r_resched   <= n_resched;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_wb_idx <= n_wb_idx;
        r_out    <= n_out;
    end

    // Only created tasks can be ready
    a_ready_created: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ready & ~r_created) == '0)
        else $error("ready task that was never created");

    // Once started, the running task is a created one
    a_running_created: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |-> r_created[r_running])
        else $error("running task not created");

    // The delay walk only runs after start
    a_scan_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> r_started)
        else $error("delay walk before start");

    // An accepted transaction always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != ST_IDLE))
        else $error("accept did not start processing");

endmodule
